### src/naa_pkg.sv
// Shared types, constants and table functions for the neuron aggregate/activate unit.
// Used by naa_ctrl, naa_datapath and neuron_aggregate_activate_unit; depends on nothing.
`timescale 1ns / 1ps

package naa_pkg;

	localparam int MAX_FANIN       = 1024;
	localparam int ACT_TABLE_DEPTH = 256;
	localparam int SIG_W           = 13;
	localparam int SOMA_W          = 40;
	localparam int ONE_Q12         = 4096;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;

	typedef enum logic [1:0] {
		REG_SUM_MODE = 2'd0,
		REG_ACT_MODE = 2'd1,
		REG_BIAS     = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		SUM_ADD = 2'd0,
		SUM_AVG = 2'd1,
		SUM_MIN = 2'd2,
		SUM_MAX = 2'd3
	} sum_mode_t;

	typedef enum logic [1:0] {
		ACT_SIGMOID     = 2'd0,
		ACT_TANH        = 2'd1,
		ACT_RELU        = 2'd2,
		ACT_SIGMOID_ALT = 2'd3
	} act_mode_t;

	typedef enum logic [3:0] {
		ST_ACC,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_FIN,
		ST_LOOKUP,
		ST_INTERP,
		ST_ACT,
		ST_DER,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic take;
		logic accum;
		logic div_init;
		logic div_step;
		logic div_fin;
		logic lookup;
		logic interp;
		logic act;
		logic der;
	} cmd_t;

	typedef struct packed {
		logic s1_valid;
		logic s1_last;
		logic avg_mode;
		logic div_last;
	} status_t;

	// Unsigned shift-and-subtract division, only used while building the table.
	function automatic longint unsigned udiv(longint unsigned num, longint unsigned dvs);
		longint unsigned quo;
		longint unsigned rem;
		quo = 64'd0;
		rem = 64'd0;
		for (int b = 63; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			quo = quo << 1;
			if (rem >= dvs) begin
				rem = rem - dvs;
				quo = quo | 64'd1;
			end
		end
		return quo;
	endfunction

	// exp(-f) in Q30 for f in [0, 1.0], truncated power series.
	function automatic longint unsigned exp_neg_unit(longint unsigned f);
		longint          acc;
		longint unsigned term;
		acc  = longint'(Q30_ONE);
		term = Q30_ONE;
		for (int k = 1; k <= 16; k++) begin
			term = udiv((term * f) >> 30, longint'(k));
			if ((k & 1) == 1)
				acc = acc - longint'(term);
			else
				acc = acc + longint'(term);
		end
		return (acc < 0) ? 64'd0 : longint'(acc);
	endfunction

	// exp(-x) in Q30 for x in [0, 16.0].
	function automatic longint unsigned exp_neg(longint unsigned x);
		longint unsigned n;
		longint unsigned r;
		longint unsigned e1;
		n  = x >> 30;
		r  = exp_neg_unit(x & (Q30_ONE - 1));
		e1 = exp_neg_unit(Q30_ONE);
		for (int j = 0; j < 16; j++) begin
			if (longint'(j) < longint'(n))
				r = (r * e1) >> 30;
		end
		return r;
	endfunction

	// Sigmoid table entry i, Q12, evaluated at elaboration.
	function automatic logic [SIG_W-1:0] sig_entry(int unsigned i);
		longint unsigned x;
		longint unsigned den;
		longint unsigned val;
		x   = udiv((longint'(i) * 16) << 30, longint'(ACT_TABLE_DEPTH));
		den = Q30_ONE + exp_neg(x);
		val = udiv((64'd1 << 42) + (den >> 1), den);
		return val[SIG_W-1:0];
	endfunction

endpackage

### src/neuron_aggregate_activate_unit.sv
// Top level of the neuron aggregate/activate unit.
// Depends on naa_pkg, naa_ctrl and naa_datapath.
`timescale 1ns / 1ps

// Input words stream in at one per cycle: each word's value and weight are
// multiplied in a product register and folded into the 40-bit soma on the
// next cycle (sum, average, minimum or maximum; the first word of a vector
// starts from the bias). After the last word the unit stops taking input
// and finishes the vector: in sum, minimum and maximum modes the result is
// valid after the accumulate, table lookup, interpolation, activation and
// derivative steps; average mode adds a bit-serial divide of the soma by
// the input count before the lookup, one quotient bit per cycle. The result
// word is held until taken, and the next vector's first word is accepted in
// the cycle after that. Configuration writes must happen while the unit is
// idle.
module neuron_aggregate_activate_unit #(
	parameter int MAX_FANIN = naa_pkg::MAX_FANIN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] in_value,
	input  logic signed [15:0] weight,
	input  logic               last_input,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] activation_out,
	output logic signed [15:0] derivative_out
);

	naa_pkg::cmd_t    cmd;
	naa_pkg::status_t sts;

	// The controller sequences accumulation, divide and activation.
	naa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds configuration, soma, divider and lookup registers.
	naa_datapath #(
		.MAX_FANIN (MAX_FANIN)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_addr       (cfg_addr),
		.cfg_wdata      (cfg_wdata),
		.in_value       (in_value),
		.weight         (weight),
		.last_input     (last_input),
		.cmd            (cmd),
		.sts            (sts),
		.activation_out (activation_out),
		.derivative_out (derivative_out)
	);

endmodule

### src/naa_ctrl.sv
// Controller state machine of the neuron aggregate/activate unit.
// Depends on naa_pkg; drives commands to naa_datapath and reads its status.
`timescale 1ns / 1ps

module naa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  naa_pkg::status_t sts,
	output naa_pkg::cmd_t    cmd
);

	naa_pkg::state_t state_q;
	naa_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= naa_pkg::ST_ACC;
		else
			state_q <= state_nxt;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			naa_pkg::ST_ACC: begin
				if (sts.s1_valid && sts.s1_last)
					state_nxt = sts.avg_mode ? naa_pkg::ST_DIV_INIT : naa_pkg::ST_LOOKUP;
			end
			naa_pkg::ST_DIV_INIT: state_nxt = naa_pkg::ST_DIV;
			naa_pkg::ST_DIV: begin
				if (sts.div_last)
					state_nxt = naa_pkg::ST_DIV_FIN;
			end
			naa_pkg::ST_DIV_FIN: state_nxt = naa_pkg::ST_LOOKUP;
			naa_pkg::ST_LOOKUP:  state_nxt = naa_pkg::ST_INTERP;
			naa_pkg::ST_INTERP:  state_nxt = naa_pkg::ST_ACT;
			naa_pkg::ST_ACT:     state_nxt = naa_pkg::ST_DER;
			naa_pkg::ST_DER:     state_nxt = naa_pkg::ST_OUT;
			naa_pkg::ST_OUT: begin
				if (out_ready)
					state_nxt = naa_pkg::ST_ACC;
			end
			default: state_nxt = naa_pkg::ST_ACC;
		endcase
	end

	always_comb begin
		in_ready     = (state_q == naa_pkg::ST_ACC) && !(sts.s1_valid && sts.s1_last);
		out_valid    = (state_q == naa_pkg::ST_OUT);
		cmd          = '0;
		cmd.take     = in_valid && in_ready;
		cmd.accum    = (state_q == naa_pkg::ST_ACC) && sts.s1_valid;
		cmd.div_init = (state_q == naa_pkg::ST_DIV_INIT);
		cmd.div_step = (state_q == naa_pkg::ST_DIV);
		cmd.div_fin  = (state_q == naa_pkg::ST_DIV_FIN);
		cmd.lookup   = (state_q == naa_pkg::ST_LOOKUP);
		cmd.interp   = (state_q == naa_pkg::ST_INTERP);
		cmd.act      = (state_q == naa_pkg::ST_ACT);
		cmd.der      = (state_q == naa_pkg::ST_DER);
	end

	a_ready_only_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == naa_pkg::ST_ACC)
		else $error("input ready outside accumulate state");

	a_last_leaves_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == naa_pkg::ST_ACC && sts.s1_valid && sts.s1_last) |=>
		state_q != naa_pkg::ST_ACC)
		else $error("last word did not start the finish sequence");

	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before it was taken");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken while a result waits");

endmodule

### src/naa_datapath.sv
// Datapath of the neuron aggregate/activate unit: registers, accumulator,
// serial divider and interpolated sigmoid lookup. Depends on naa_pkg.
`timescale 1ns / 1ps

module naa_datapath #(
	parameter int MAX_FANIN = naa_pkg::MAX_FANIN
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	input  logic signed [15:0] in_value,
	input  logic signed [15:0] weight,
	input  logic               last_input,
	input  naa_pkg::cmd_t      cmd,
	output naa_pkg::status_t   sts,
	output logic signed [15:0] activation_out,
	output logic signed [15:0] derivative_out
);

	localparam int CNT_W  = $clog2(MAX_FANIN + 1);
	localparam int SW     = naa_pkg::SOMA_W;
	localparam int DCNT_W = $clog2(SW);
	localparam int DEPTH  = naa_pkg::ACT_TABLE_DEPTH;
	localparam int TBL_AW = $clog2(DEPTH + 1);
	localparam int SIG_W  = naa_pkg::SIG_W;

	// Constant sigmoid table.
	logic [SIG_W-1:0] sig_tbl [0:DEPTH];
	for (genvar g = 0; g <= DEPTH; g++) begin : g_tbl
		assign sig_tbl[g] = naa_pkg::sig_entry(g);
	end

	// Configuration registers.
	logic [1:0]         sum_mode_q;
	logic [1:0]         act_mode_q;
	logic signed [31:0] bias_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_mode_q <= naa_pkg::SUM_ADD;
			act_mode_q <= naa_pkg::ACT_SIGMOID;
			bias_q     <= '0;
		end else if (cfg_we) begin
			unique case (naa_pkg::reg_index_t'(cfg_addr))
				naa_pkg::REG_SUM_MODE: sum_mode_q <= cfg_wdata[1:0];
				naa_pkg::REG_ACT_MODE: act_mode_q <= cfg_wdata[1:0];
				naa_pkg::REG_BIAS:     bias_q     <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Product stage.
	logic               vld_s1;
	logic               last_s1;
	logic signed [31:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else
			vld_s1 <= cmd.take;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			prod_s1 <= in_value * weight;
			last_s1 <= last_input;
		end
	end

	// Accumulator.
	logic signed [SW-1:0] soma_q;
	logic [CNT_W-1:0]     cnt_q;
	logic signed [SW-1:0] base;
	logic signed [SW-1:0] prod_ext;
	logic signed [SW:0]   sum_w;
	logic signed [SW-1:0] sum_sat;
	logic signed [SW-1:0] acc_nxt;

	always_comb begin
		base     = (cnt_q == '0) ? SW'(bias_q) : soma_q;
		prod_ext = SW'(prod_s1);
		sum_w    = (SW + 1)'(base) + (SW + 1)'(prod_ext);
		if (sum_w[SW] != sum_w[SW-1])
			sum_sat = sum_w[SW] ? {1'b1, {(SW - 1){1'b0}}} : {1'b0, {(SW - 1){1'b1}}};
		else
			sum_sat = sum_w[SW-1:0];
		unique case (naa_pkg::sum_mode_t'(sum_mode_q))
			naa_pkg::SUM_MIN: acc_nxt = (prod_ext < base) ? prod_ext : base;
			naa_pkg::SUM_MAX: acc_nxt = (prod_ext > base) ? prod_ext : base;
			default:          acc_nxt = sum_sat;
		endcase
	end

	// Serial restoring divider for the average.
	logic [CNT_W-1:0]  rem_q;
	logic [SW-1:0]     quo_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              dneg_q;
	logic [CNT_W:0]    shl;
	logic              qbit;
	logic [CNT_W:0]    sub_w;

	always_comb begin
		shl   = {rem_q, quo_q[SW-1]};
		sub_w = shl - {1'b0, cnt_q};
		qbit  = (shl >= {1'b0, cnt_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soma_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cmd.accum) begin
				soma_q <= acc_nxt;
				if (cnt_q < CNT_W'(MAX_FANIN))
					cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.div_fin) begin
				soma_q <= dneg_q ? -$signed(quo_q) : $signed(quo_q);
			end
			if (cmd.lookup)
				cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= '0;
			quo_q  <= soma_q[SW-1] ? SW'(-soma_q) : SW'(soma_q);
			dneg_q <= soma_q[SW-1];
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= qbit ? sub_w[CNT_W-1:0] : shl[CNT_W-1:0];
			quo_q  <= {quo_q[SW-2:0], qbit};
			dcnt_q <= dcnt_q + DCNT_W'(1);
		end
	end

	// Table lookup.
	logic [SW-1:0]    mag;
	logic [SW:0]      xarg;
	logic [63:0]      pos_w;
	logic [63:0]      idx_w;
	logic [TBL_AW-1:0] idx_lo;
	logic [TBL_AW-1:0] idx_hi;
	logic             over;
	logic [SIG_W-1:0] lo_q;
	logic [SIG_W-1:0] diff_q;
	logic [23:0]      frac_q;
	logic             neg_q;
	logic             pos_q;
	logic [15:0]      relu_q;
	logic [SIG_W-1:0] sig_q;
	logic [36:0]      ip_w;

	always_comb begin
		mag    = soma_q[SW-1] ? SW'(-soma_q) : SW'(soma_q);
		xarg   = (naa_pkg::act_mode_t'(act_mode_q) == naa_pkg::ACT_TANH) ?
			{mag, 1'b0} : {1'b0, mag};
		pos_w  = 64'(xarg) * 64'(DEPTH);
		idx_w  = pos_w >> 28;
		over   = (idx_w >= 64'(DEPTH));
		idx_lo = idx_w[TBL_AW-1:0];
		idx_hi = idx_lo + TBL_AW'(1);
		ip_w   = 37'(diff_q) * 37'(frac_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			lo_q   <= over ? sig_tbl[DEPTH] : sig_tbl[idx_lo];
			diff_q <= over ? '0 : sig_tbl[idx_hi] - sig_tbl[idx_lo];
			frac_q <= pos_w[27:4];
			neg_q  <= soma_q[SW-1];
			pos_q  <= !soma_q[SW-1] && (soma_q != '0);
			if (!soma_q[SW-1] && (soma_q != '0))
				relu_q <= (|soma_q[SW-1:27]) ? 16'h7FFF : {1'b0, soma_q[26:12]};
			else
				relu_q <= '0;
		end
		if (cmd.interp)
			sig_q <= lo_q + ip_w[36:24];
	end

	// Activation and derivative.
	logic signed [15:0] act_q;
	logic signed [15:0] act_w;
	logic signed [15:0] sig_s;
	logic signed [15:0] tanh_w;
	logic signed [31:0] sq_w;
	logic signed [31:0] sd_w;
	logic signed [15:0] der_w;

	always_comb begin
		sig_s  = 16'(sig_q);
		tanh_w = (sig_s <<< 1) - 16'(naa_pkg::ONE_Q12);
		unique case (naa_pkg::act_mode_t'(act_mode_q))
			naa_pkg::ACT_TANH: act_w = neg_q ? -tanh_w : tanh_w;
			naa_pkg::ACT_RELU: act_w = relu_q;
			default:           act_w = neg_q ? 16'(naa_pkg::ONE_Q12) - sig_s : sig_s;
		endcase
		sq_w = act_q * act_q;
		sd_w = act_q * (16'(naa_pkg::ONE_Q12) - act_q);
		unique case (naa_pkg::act_mode_t'(act_mode_q))
			naa_pkg::ACT_TANH: der_w = 16'(naa_pkg::ONE_Q12) - 16'(sq_w >>> 12);
			naa_pkg::ACT_RELU: der_w = pos_q ? 16'(naa_pkg::ONE_Q12) : 16'sd0;
			default:           der_w = 16'(sd_w >>> 12);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.act)
			act_q <= act_w;
		if (cmd.der) begin
			activation_out <= act_q;
			derivative_out <= der_w;
		end
	end

	always_comb begin
		sts.s1_valid = vld_s1;
		sts.s1_last  = last_s1;
		sts.avg_mode = (naa_pkg::sum_mode_t'(sum_mode_q) == naa_pkg::SUM_AVG);
		sts.div_last = (dcnt_q == DCNT_W'(SW - 1));
	end

endmodule
